// ===== src/decimal_seconds_to_ticks_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef DECIMAL_SECONDS_TO_TICKS_MACROS_SVH
`define DECIMAL_SECONDS_TO_TICKS_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dst_pkg.sv =====
package dst_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	localparam logic [7:0]  CHAR_DOT         = 8'h2E;
	localparam logic [7:0]  CHAR_ZERO        = 8'h30;
	localparam logic [7:0]  CHAR_NINE        = 8'h39;
	localparam logic [34:0] SECONDS_LIMIT    = 35'd2147483647;
	localparam logic [3:0]  FRACTION_DIGITS  = 4'd9;
	localparam logic [5:0]  TICKS_PER_SECOND = 6'd50;
	// One tick less one nanosecond: added before the divide to round up.
	localparam logic [24:0] NS_PER_TICK_M1   = 25'd19999999;
	// ceil(2^39 / 78125); 20000000 = 256 * 78125, exact for 22-bit dividends.
	localparam logic [22:0] TICK_RECIP       = 23'd7036875;
	localparam int          RecipShift       = 39;
	localparam int          QuotW            = 6;

	typedef struct packed {
		logic [30:0] seconds;
		logic [29:0] nanos;
		status_t     status;
	} fin_t;

	function automatic logic [26:0] frac_weight(input logic [3:0] idx);
		logic [26:0] w;
		case (idx)
			4'd0: w = 27'd100000000;
			4'd1: w = 27'd10000000;
			4'd2: w = 27'd1000000;
			4'd3: w = 27'd100000;
			4'd4: w = 27'd10000;
			4'd5: w = 27'd1000;
			4'd6: w = 27'd100;
			4'd7: w = 27'd10;
			4'd8: w = 27'd1;
			default: w = 27'd0;
		endcase
		return w;
	endfunction

endpackage

// ===== src/dst_if.sv =====
interface dst_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       no_char;
	logic       last;

	modport source (output valid, output char_code, output no_char, output last, input ready);
	modport sink (input valid, input char_code, input no_char, input last, output ready);
endinterface

interface dst_result_if;
	logic        valid;
	logic        ready;
	logic [36:0] tick_count;
	logic [30:0] whole_seconds;
	logic [29:0] nanoseconds;
	logic [1:0]  status;

	modport source (output valid, output tick_count, output whole_seconds,
		output nanoseconds, output status, input ready);
	modport sink (input valid, input tick_count, input whole_seconds,
		input nanoseconds, input status, output ready);
endinterface

// ===== src/dst_parse.sv =====
module dst_parse (
	input  logic          clk,
	input  logic          arst_n,
	dst_char_if.sink      chars,
	output dst_pkg::fin_t fin,
	output logic          fin_valid,
	input  logic          fin_ready
);
	import dst_pkg::*;

	logic        in_frac_q;
	logic [30:0] sec_q;
	logic [29:0] ns_q;
	logic [3:0]  idx_q;
	status_t     err_q;

	fin_t        fin_s1;
	logic        valid_s1;

	logic        accept;
	logic        is_digit;
	logic [3:0]  digit;
	logic [34:0] sec_mul;
	logic [30:0] ns_term;
	logic [30:0] ns_sum;

	logic        in_frac_n;
	logic [30:0] sec_n;
	logic [29:0] ns_n;
	logic [3:0]  idx_n;
	status_t     err_n;
	fin_t        fin_d;

	assign accept   = chars.valid && chars.ready;
	assign is_digit = (chars.char_code >= CHAR_ZERO) && (chars.char_code <= CHAR_NINE);
	assign digit    = chars.char_code[3:0];

	assign sec_mul = ({4'b0, sec_q} << 3) + ({4'b0, sec_q} << 1) + 35'(digit);
	assign ns_term = 31'(digit) * 31'(frac_weight(idx_q));
	assign ns_sum  = 31'(ns_q) + ns_term;

	always_comb begin
		in_frac_n = in_frac_q;
		sec_n     = sec_q;
		ns_n      = ns_q;
		idx_n     = idx_q;
		err_n     = err_q;
		// Once an error is latched, the rest of the string is ignored.
		if (!chars.no_char && err_q == ST_OK) begin
			if (!in_frac_q) begin
				if (chars.char_code == CHAR_DOT) begin
					in_frac_n = 1'b1;
				end else if (!is_digit) begin
					err_n = ST_INVALID;
				end else if (sec_mul > SECONDS_LIMIT) begin
					err_n = ST_TOO_LARGE;
				end else begin
					sec_n = sec_mul[30:0];
				end
			end else begin
				if (!is_digit) begin
					err_n = ST_INVALID;
				end else if (idx_q < FRACTION_DIGITS) begin
					ns_n  = ns_sum[29:0];
					idx_n = idx_q + 4'd1;
				end
			end
		end

		fin_d.status = err_n;
		if (err_n == ST_OK) begin
			fin_d.seconds = sec_n;
			fin_d.nanos   = ns_n;
		end else begin
			fin_d.seconds = '0;
			fin_d.nanos   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frac_q <= 1'b0;
			sec_q     <= '0;
			ns_q      <= '0;
			idx_q     <= '0;
			err_q     <= ST_OK;
		end else if (accept) begin
			if (chars.last) begin
				in_frac_q <= 1'b0;
				sec_q     <= '0;
				ns_q      <= '0;
				idx_q     <= '0;
				err_q     <= ST_OK;
			end else begin
				in_frac_q <= in_frac_n;
				sec_q     <= sec_n;
				ns_q      <= ns_n;
				idx_q     <= idx_n;
				err_q     <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && chars.last) begin
			valid_s1 <= 1'b1;
		end else if (fin_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chars.last) begin
			fin_s1 <= fin_d;
		end
	end

	assign chars.ready = !valid_s1 || fin_ready;
	assign fin         = fin_s1;
	assign fin_valid   = valid_s1;

endmodule

// ===== src/dst_tick.sv =====
module dst_tick (
	input  logic          clk,
	input  logic          arst_n,
	input  dst_pkg::fin_t fin,
	input  logic          fin_valid,
	output logic          fin_ready,
	dst_result_if.source  result
);
	import dst_pkg::*;

	logic [30:0]      ns_round;
	logic [21:0]      ns_div256;
	logic [44:0]      recip_prod;
	logic [36:0]      sec50;

	logic [36:0]      sec50_s2;
	logic [QuotW-1:0] quot_s2;
	fin_t             fin_s2;
	logic             valid_s2;

	logic [36:0]      tick_q;
	fin_t             fin_q;
	logic             valid_q;

	logic             out_adv;

	// ceil(ns / 20000000) = floor(((ns + 19999999) >> 8) / 78125).
	assign ns_round   = 31'(fin.nanos) + 31'(NS_PER_TICK_M1);
	assign ns_div256  = ns_round[29:8];
	assign recip_prod = 45'(ns_div256) * 45'(TICK_RECIP);
	assign sec50      = 37'(fin.seconds) * 37'(TICKS_PER_SECOND);

	assign out_adv   = !valid_q || result.ready;
	assign fin_ready = !valid_s2 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (fin_ready) begin
				valid_s2 <= fin_valid;
			end
			if (out_adv) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ready && fin_valid) begin
			sec50_s2 <= sec50;
			quot_s2  <= recip_prod[RecipShift+QuotW-1:RecipShift];
			fin_s2   <= fin;
		end
		if (out_adv && valid_s2) begin
			tick_q <= sec50_s2 + 37'(quot_s2);
			fin_q  <= fin_s2;
		end
	end

	assign result.valid         = valid_q;
	assign result.tick_count    = tick_q;
	assign result.whole_seconds = fin_q.seconds;
	assign result.nanoseconds   = fin_q.nanos;
	assign result.status        = fin_q.status;

endmodule

// ===== src/decimal_seconds_to_ticks.sv =====
// Converts a decimal duration string such as 12.345 into 1/50 second ticks.
// The chars channel takes one character per request; no_char marks a request
// that carries no character (an empty string) and last ends the string.
// Requests without last produce nothing; the request with last produces one
// request on the result channel with tick_count, whole_seconds, nanoseconds
// and status (0 ok, 1 invalid character, 2 seconds too large). On an error
// the three numeric fields are zero.
// One character is accepted every cycle while chars.ready is high; the seconds
// and nanosecond accumulators update from each accepted character.
// After the edge that accepts the last character, one stage holds the parsed
// values, one holds the multiply by 50 and the reciprocal multiply for the
// rounded-up tick fraction, and the output register holds the sum.
// When the receiver holds ready low, the output register keeps its result
// and the pipeline fills; chars.ready drops only once every stage is full.
// Reset clears all accumulators and valid flags; the block is ready at once.
module decimal_seconds_to_ticks (
	input  logic         clk,
	input  logic         arst_n,
	dst_char_if.sink     chars,
	dst_result_if.source result
);
	import dst_pkg::*;

	fin_t fin;
	logic fin_valid;
	logic fin_ready;

	dst_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.fin       (fin),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready)
	);

	dst_tick u_tick (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin       (fin),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.result    (result)
	);

endmodule

// ===== src/dst_checker.sv =====
`include "decimal_seconds_to_ticks_macros.svh"

module dst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [36:0] tick_count,
	input logic [30:0] whole_seconds,
	input logic [29:0] nanoseconds,
	input logic [1:0]  status
);
	import dst_pkg::*;

	logic err_seen;
	logic [36:0] tick_floor;

	assign err_seen   = (status != ST_OK);
	assign tick_floor = 37'(whole_seconds) * 37'(TICKS_PER_SECOND);

	`DST_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
		out_valid && $stable(tick_count) && $stable(status), "stalled result changed")
	`DST_ASSERT_NOW(a_error_zeroes, out_valid && err_seen,
		tick_count == 37'd0 && whole_seconds == 31'd0 && nanoseconds == 30'd0,
		"error result carries nonzero fields")
	`DST_ASSERT_NOW(a_status_code, out_valid,
		status == ST_OK || status == ST_INVALID || status == ST_TOO_LARGE,
		"undefined status code")
	`DST_ASSERT_NOW(a_tick_range, out_valid && !err_seen,
		tick_count >= tick_floor && tick_count <= tick_floor + 37'd50
		&& nanoseconds <= 30'd999999999, "tick count outside the seconds bracket")

endmodule

bind decimal_seconds_to_ticks dst_checker u_dst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.tick_count    (result.tick_count),
	.whole_seconds (result.whole_seconds),
	.nanoseconds   (result.nanoseconds),
	.status        (result.status)
);

// ===== bench/tb.sv =====
module tb;
	import dst_pkg::*;

	typedef struct {
		logic [36:0] ticks;
		logic [30:0] secs;
		logic [29:0] nanos;
		status_t     status;
	} tick_result_t;

	typedef struct {
		logic [7:0] code;
		logic       skip;
		logic       ends;
	} char_item_t;

	localparam longint unsigned NsPerTick = 64'd20000000;
	localparam int HoldOff = 150;

	class tick_checker;
		bit           in_fraction;
		bit [30:0]    seconds;
		bit [29:0]    nanos;
		bit [26:0]    digit_weight;
		status_t      parse_status;
		tick_result_t expected_ticks[$];
		int           mismatches;
		int           strings_done;
		int           status_seen[3];

		function new();
			restart();
			mismatches = 0;
			strings_done = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void restart();
			in_fraction = 1'b0;
			seconds = '0;
			nanos = '0;
			digit_weight = 27'd100000000;
			parse_status = ST_OK;
		endfunction

		function void complain(string what);
			mismatches++;
			if (mismatches <= 10) $display("%s", what);
		endfunction

		function void note_char(logic [7:0] code, logic skip, logic ends);
			logic [34:0]     grown;
			logic [3:0]      value;
			logic            is_digit;
			longint unsigned frac_ticks;
			tick_result_t    res;
			is_digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
			value = 4'(code - CHAR_ZERO);
			// Once an error is set, the rest of the string is ignored.
			if (!skip && parse_status == ST_OK) begin
				if (!in_fraction) begin
					if (code == CHAR_DOT) begin
						in_fraction = 1'b1;
					end else if (!is_digit) begin
						parse_status = ST_INVALID;
					end else begin
						grown = 35'(seconds) * 35'd10 + 35'(value);
						if (grown > SECONDS_LIMIT) parse_status = ST_TOO_LARGE;
						else seconds = grown[30:0];
					end
				end else if (!is_digit) begin
					parse_status = ST_INVALID;
				end else begin
					// Past the ninth digit the weight has fallen to zero.
					nanos = nanos + 30'(value) * 30'(digit_weight);
					digit_weight = digit_weight / 27'd10;
				end
			end
			if (ends) begin
				res.status = parse_status;
				if (parse_status == ST_OK) begin
					frac_ticks = (64'(nanos) + NsPerTick - 64'd1) / NsPerTick;
					res.ticks = 37'(64'(seconds) * 64'd50 + frac_ticks);
					res.secs = seconds;
					res.nanos = nanos;
				end else begin
					res.ticks = '0;
					res.secs = '0;
					res.nanos = '0;
				end
				expected_ticks.push_back(res);
				status_seen[parse_status]++;
				strings_done++;
				restart();
			end
		endfunction

		function void check_ticks(tick_result_t got);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				complain($sformatf("unexpected result: ticks=%0d s=%0d ns=%0d status=%0d",
					got.ticks, got.secs, got.nanos, got.status));
			end else begin
				want = expected_ticks.pop_front();
				if (got.ticks !== want.ticks || got.secs !== want.secs
						|| got.nanos !== want.nanos || got.status !== want.status) begin
					complain($sformatf({"mismatch: expected ticks=%0d s=%0d ns=%0d status=%0d,",
						" got ticks=%0d s=%0d ns=%0d status=%0d"},
						want.ticks, want.secs, want.nanos, want.status,
						got.ticks, got.secs, got.nanos, got.status));
				end
			end
		endfunction

		function void flush_leftovers();
			tick_result_t want;
			while (expected_ticks.size() > 0) begin
				want = expected_ticks.pop_front();
				complain($sformatf("missing result: expected ticks=%0d status=%0d",
					want.ticks, want.status));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dst_char_if   chars_if();
	dst_result_if result_if();

	decimal_seconds_to_ticks dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	tick_checker ticks_sb;
	char_item_t  word_q[$];
	bit          sender_idles;
	bit          receiver_idles;
	int          hold_off_cycles;
	int          chars_taken;
	int          input_stalls;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic char_item_t make_gap();
		char_item_t it;
		it.code = 8'($urandom_range(0, 255));
		it.skip = 1'b1;
		it.ends = 1'b0;
		return it;
	endfunction

	task automatic add_char(logic [7:0] code);
		char_item_t it;
		it.code = code;
		it.skip = 1'b0;
		it.ends = 1'b0;
		word_q.push_back(it);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i]);
	endtask

	task automatic add_digits(int count, bit lean_nine);
		repeat (count) begin
			if (lean_nine && $urandom_range(0, 1)) add_char(CHAR_NINE);
			else add_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
		end
	endtask

	task automatic add_well_formed();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
		add_digits(n, 1'b0);
		if ($urandom_range(0, 3) != 0) begin
			add_char(CHAR_DOT);
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
			add_digits(n, $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic make_random_word();
		int         kind;
		char_item_t bad;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			add_well_formed();
		end else if (kind < 70) begin
			// Seconds around the signed 31-bit limit, or one digit beyond it.
			add_text("214748364");
			add_digits(1 + $urandom_range(0, 1), 1'b0);
			if ($urandom_range(0, 1)) begin
				add_char(CHAR_DOT);
				add_digits(9, 1'b1);
			end
		end else if (kind < 85) begin
			add_well_formed();
			bad.code = ($urandom_range(0, 3) == 0) ? CHAR_DOT : 8'($urandom_range(0, 255));
			bad.skip = 1'b0;
			bad.ends = 1'b0;
			word_q.insert($urandom_range(0, word_q.size()), bad);
		end else begin
			repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0) word_q.insert($urandom_range(0, word_q.size()), make_gap());
	endtask

	// Sends the queued characters as one string; valid stays high between requests
	// unless an idle burst is drawn.
	task automatic send_word();
		if (word_q.size() == 0) word_q.push_back(make_gap());
		word_q[word_q.size() - 1].ends = 1'b1;
		foreach (word_q[i]) begin
			if (sender_idles && $urandom_range(0, 9) == 0) begin
				chars_if.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			chars_if.valid     <= 1'b1;
			chars_if.char_code <= word_q[i].code;
			chars_if.no_char   <= word_q[i].skip;
			chars_if.last      <= word_q[i].ends;
			do @(posedge clk); while (chars_if.ready !== 1'b1);
			ticks_sb.note_char(word_q[i].code, word_q[i].skip, word_q[i].ends);
			chars_taken++;
		end
		word_q.delete();
	endtask

	initial begin
		tick_result_t got;
		int           stall_left;
		stall_left = 0;
		input_stalls = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
					got.ticks  = result_if.tick_count;
					got.secs   = result_if.whole_seconds;
					got.nanos  = result_if.nanoseconds;
					got.status = status_t'(result_if.status);
					ticks_sb.check_ticks(got);
				end
				if (chars_if.valid === 1'b1 && chars_if.ready !== 1'b1) input_stalls++;
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		bit pressed;
		pressed = 1'b0;
		ticks_sb = new();
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		hold_off_cycles = 0;
		chars_taken = 0;
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= '0;
		chars_if.no_char   <= 1'b0;
		chars_if.last      <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Empty string, lone dot, non-digit extremes, a request with no character
		// inside a string, a second dot, and the largest duration.
		send_word();
		add_char(CHAR_DOT);
		send_word();
		add_char(8'hFF);
		send_word();
		add_char(8'h00);
		send_word();
		add_text("9");
		word_q.push_back(make_gap());
		add_text(".5");
		send_word();
		add_text(".5.");
		send_word();
		add_text("2147483647.999999999");
		send_word();

		while (chars_taken < 800) begin
			if (!pressed && chars_taken >= 300) begin
				// Short strings against a stalled receiver fill the pipeline.
				pressed = 1'b1;
				sender_idles = 1'b0;
				hold_off_cycles = HoldOff;
				repeat (30) begin
					add_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
					send_word();
				end
			end
			sender_idles = (chars_taken < 680);
			receiver_idles = (chars_taken < 680);
			make_random_word();
			send_word();
		end
		chars_if.valid <= 1'b0;

		for (int c = 0; c < 5000 && ticks_sb.expected_ticks.size() > 0; c++) @(posedge clk);
		repeat (8) @(posedge clk);
		ticks_sb.flush_leftovers();

		$display("Parsed %0d strings from %0d character requests: %0d ok, %0d invalid, %0d too large.",
			ticks_sb.strings_done, chars_taken, ticks_sb.status_seen[ST_OK],
			ticks_sb.status_seen[ST_INVALID], ticks_sb.status_seen[ST_TOO_LARGE]);
		$display("Result side held off %0d cycles once; input was back-pressured on %0d cycles.",
			HoldOff, input_stalls);
		if (ticks_sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/dst_pkg.sv
src/dst_if.sv
src/dst_parse.sv
src/dst_tick.sv
src/decimal_seconds_to_ticks.sv
src/dst_checker.sv
bench/tb.sv
